[rtl/kdeq_pkg.sv]
// shared types, constants and the key map for the keypad debounce event queue
// no dependencies; imported by the event ring, the core, the checker and the bench
package kdeq_pkg;

    // default geometry of the keypad and the event ring
    localparam int NUM_COLUMNS_DEF  = 4;
    localparam int NUM_ROWS_DEF     = 4;
    localparam int HISTORY_BITS_DEF = 8;
    localparam int RING_DEPTH_DEF   = 2;

    // fixed port field widths
    localparam int COLUMN_W   = 2;
    localparam int ROW_BITS_W = 4;
    localparam int CHAR_W     = 7;
    localparam int EVENT_W    = CHAR_W + 1;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 16;
    localparam int MAX_ROWS   = 8;
    localparam int KEY_MAP_N  = 16;

    // item kind carried on tuser
    typedef enum logic {
        KIND_SCAN = 1'b0,
        KIND_POP  = 1'b1
    } kind_t;

    // one popped result
    typedef struct packed {
        logic [CHAR_W-1:0] key_char;
        logic              pressed;
        logic              event_valid;
    } event_t;

    // ascii codes of the keys, indexed by column * rows + row
    localparam logic [CHAR_W-1:0] KEY_MAP [KEY_MAP_N] = '{
        7'h44, 7'h43, 7'h42, 7'h41, 7'h23, 7'h39, 7'h36, 7'h33,
        7'h30, 7'h38, 7'h35, 7'h32, 7'h2a, 7'h37, 7'h34, 7'h31
    };

endpackage

[rtl/kdeq_hist_ram.sv]
// column history memory: one row per keypad column, registered read
// depends on nothing; instantiated by keypad_debounce_event_queue_core
module kdeq_hist_ram #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/kdeq_event_ring.sv]
// event ring: in-order pushes that overwrite without a full check, one pop
// depends on kdeq_pkg; instantiated by keypad_debounce_event_queue_core
module kdeq_event_ring #(
    parameter int NUM_PUSH   = 4,
    parameter int RING_DEPTH = 2
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [NUM_PUSH-1:0]     push_valid,
    input  logic [kdeq_pkg::EVENT_W-1:0] push_data [NUM_PUSH],
    input  logic                    pop_req,
    output kdeq_pkg::event_t        pop_result
);
    import kdeq_pkg::*;

    localparam int SW = $clog2(RING_DEPTH);
    localparam logic [SW-1:0] LAST_SLOT = SW'(RING_DEPTH - 1);

    logic [EVENT_W-1:0] ring_reg  [RING_DEPTH];
    logic [EVENT_W-1:0] ring_next [RING_DEPTH];
    logic [SW-1:0]      write_slot_reg, write_slot_next;
    logic [SW-1:0]      read_slot_reg, read_slot_next;
    logic [EVENT_W-1:0] head;

    assign head = ring_reg[read_slot_reg];

    // head entry as a result, zero entry means empty
    always_comb
    begin
        pop_result.event_valid = (head != '0);
        pop_result.pressed     = head[EVENT_W-1];
        pop_result.key_char    = head[CHAR_W-1:0];
    end

    // pushes in row order, then the pop
    always_comb
    begin
        ring_next       = ring_reg;
        write_slot_next = write_slot_reg;
        read_slot_next  = read_slot_reg;
        for (int i = 0; i < NUM_PUSH; i++)
        begin
            if (push_valid[i])
            begin
                ring_next[write_slot_next] = push_data[i];
                write_slot_next = (write_slot_next == LAST_SLOT) ? '0
                                                                 : write_slot_next + 1'b1;
            end
        end
        if (pop_req && (head != '0))
        begin
            ring_next[read_slot_reg] = '0;
            read_slot_next = (read_slot_reg == LAST_SLOT) ? '0 : read_slot_reg + 1'b1;
        end
    end

    // ring state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RING_DEPTH; i++)
            begin
                ring_reg[i] <= '0;
            end
            write_slot_reg <= '0;
            read_slot_reg  <= '0;
        end
        else
        begin
            ring_reg       <= ring_next;
            write_slot_reg <= write_slot_next;
            read_slot_reg  <= read_slot_next;
        end
    end

endmodule

[rtl/keypad_debounce_event_queue_core.sv]
// Keypad debouncer with a small event queue. A scan beat (tuser = 0) carries one
// column and its row readings; each key of that column shifts its reading into
// a history, and a history of only the newest bit set queues a press event, a
// history of all ones but the newest bit queues a release event. A pop beat
// (tuser = 1) returns the event at the ring's read slot, or event_valid = 0 when
// the queue is empty. One beat is taken every cycle while s_tready is high; a pop
// result goes through the writeback stage and the output register to the master
// side. s_tready falls only while a pop waits behind an output beat that is not
// yet taken. The rate is set by the column history memory: it is read on
// acceptance and written back from the writeback stage, with the last write
// forwarded to a following scan of the same column. Histories read as zero
// after reset until their column is first scanned, so no clearing pass is needed.
module keypad_debounce_event_queue_core #(
    parameter int NUM_COLUMNS  = kdeq_pkg::NUM_COLUMNS_DEF,
    parameter int NUM_ROWS     = kdeq_pkg::NUM_ROWS_DEF,
    parameter int HISTORY_BITS = kdeq_pkg::HISTORY_BITS_DEF,
    parameter int RING_DEPTH   = kdeq_pkg::RING_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [kdeq_pkg::S_TDATA_W-1:0] s_tdata,  // column[1:0], row_bits[5:2], zeros
    input  logic                           s_tuser,  // kind[0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [kdeq_pkg::M_TDATA_W-1:0] m_tdata   // event_valid[0], pressed[1],
                                                     // key_char[8:2], zeros
);
    import kdeq_pkg::*;

    localparam int AW     = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
    localparam int ROW_W  = NUM_ROWS * HISTORY_BITS;
    localparam logic [HISTORY_BITS-1:0] PRESS_PAT   = HISTORY_BITS'(1);
    localparam logic [HISTORY_BITS-1:0] RELEASE_PAT = ~HISTORY_BITS'(1);

    // input beat fields
    logic [COLUMN_W-1:0]   in_column;
    logic [ROW_BITS_W-1:0] in_rows;
    logic                  in_range;
    logic                  s_accept;

    assign in_column = s_tdata[COLUMN_W-1:0];
    assign in_rows   = s_tdata[COLUMN_W +: ROW_BITS_W];
    assign in_range  = ({{(32-COLUMN_W){1'b0}}, in_column} < 32'(NUM_COLUMNS));
    assign s_accept  = s_tvalid && s_tready;

    // writeback stage registers
    logic                  s1_valid_reg;
    kind_t                 s1_kind_reg;
    logic [COLUMN_W-1:0]   s1_column_reg;
    logic [ROW_BITS_W-1:0] s1_rows_reg;
    logic                  s1_range_reg;
    logic                  s1_hv_reg;
    logic [NUM_COLUMNS-1:0] hist_valid_reg;
    logic                  fwd_valid_reg;
    logic [COLUMN_W-1:0]   fwd_column_reg;
    logic [ROW_W-1:0]      fwd_data_reg;
    logic                  out_valid_reg;
    event_t                out_event_reg;

    logic                  out_free;
    logic                  s1_go;
    logic                  pop_req;
    logic                  hist_wr;
    logic [ROW_W-1:0]      rd_data;
    logic [ROW_W-1:0]      hist_base;
    logic [ROW_W-1:0]      hist_new;
    logic [NUM_ROWS-1:0]   push_valid;
    logic [EVENT_W-1:0]    push_data [NUM_ROWS];
    event_t                pop_result;

    // flow control
    assign out_free = !out_valid_reg || m_tready;
    assign s1_go    = s1_valid_reg && ((s1_kind_reg == KIND_SCAN) || out_free);
    assign s_tready = !s1_valid_reg || s1_go;
    assign pop_req  = s1_valid_reg && (s1_kind_reg == KIND_POP) && out_free;
    assign hist_wr  = s1_valid_reg && (s1_kind_reg == KIND_SCAN) && s1_range_reg;

    // history memory
    kdeq_hist_ram #(
        .DEPTH (NUM_COLUMNS),
        .WIDTH (ROW_W),
        .AW    (AW)
    ) u_hist_ram (
        .clk     (clk),
        .wr_en   (hist_wr),
        .wr_addr (AW'(s1_column_reg)),
        .wr_data (hist_new),
        .rd_en   (s_accept),
        .rd_addr (AW'(in_column)),
        .rd_data (rd_data)
    );

    // old histories: forwarded write, stored row, or reset value
    always_comb
    begin
        if (fwd_valid_reg && (fwd_column_reg == s1_column_reg))
        begin
            hist_base = fwd_data_reg;
        end
        else if (s1_hv_reg)
        begin
            hist_base = rd_data;
        end
        else
        begin
            hist_base = '0;
        end
    end

    // shift each key's reading in and detect press and release patterns
    always_comb
    begin
        logic [MAX_ROWS-1:0]     rows_wide;
        logic [HISTORY_BITS-1:0] h;
        logic [3:0]              key_idx;
        rows_wide = {{(MAX_ROWS-ROW_BITS_W){1'b0}}, s1_rows_reg};
        hist_new  = '0;
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            h = {hist_base[r*HISTORY_BITS +: HISTORY_BITS-1], rows_wide[r]};
            hist_new[r*HISTORY_BITS +: HISTORY_BITS] = h;
            key_idx = 4'(int'(s1_column_reg) * NUM_ROWS + r);
            push_valid[r] = hist_wr && ((h == PRESS_PAT) || (h == RELEASE_PAT));
            push_data[r]  = {(h == PRESS_PAT), KEY_MAP[key_idx]};
        end
    end

    // event ring
    kdeq_event_ring #(
        .NUM_PUSH   (NUM_ROWS),
        .RING_DEPTH (RING_DEPTH)
    ) u_event_ring (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .pop_req    (pop_req),
        .pop_result (pop_result)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            hist_valid_reg <= '0;
            fwd_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (hist_wr)
            begin
                hist_valid_reg[AW'(s1_column_reg)] <= 1'b1;
            end
            fwd_valid_reg <= hist_wr;
            if (pop_req)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_kind_reg   <= kind_t'(s_tuser);
            s1_column_reg <= in_column;
            s1_rows_reg   <= in_rows;
            s1_range_reg  <= in_range;
            s1_hv_reg     <= hist_valid_reg[AW'(in_column)];
        end
        if (hist_wr)
        begin
            fwd_column_reg <= s1_column_reg;
            fwd_data_reg   <= hist_new;
        end
        if (pop_req)
        begin
            out_event_reg <= pop_result;
        end
    end

    // master side
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-EVENT_W-1){1'b0}}, out_event_reg};

endmodule

[rtl/kdeq_checker.sv]
// port-level checks for the keypad debounce event queue, bound to the top level
// depends on kdeq_pkg and keypad_debounce_event_queue_core
module kdeq_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [kdeq_pkg::M_TDATA_W-1:0] m_tdata
);
    import kdeq_pkg::*;

    // a stalled result beat holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // an empty pop carries no event content
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[EVENT_W:1] == '0)
        else $error("empty pop carries event bits");

    // a real event always has a key code
    a_event_char: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[EVENT_W:2] != '0)
        else $error("event without key code");

    // result padding stays zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[M_TDATA_W-1:EVENT_W+1] == '0)
        else $error("result padding not zero");

    // input is never refused with no result pending
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid && $past(!m_tvalid) |-> s_tready)
        else $error("input refused while output side is free");

endmodule

bind keypad_debounce_event_queue_core kdeq_checker u_kdeq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[verif/tb.sv]
// self-checking bench for keypad_debounce_event_queue_core: scan and pop beats in,
// popped events out, checked against a built-in debounce and ring predictor
// depends on rtl/kdeq_pkg.sv and rtl/keypad_debounce_event_queue_core.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kdeq_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 1000;
    localparam int DRAIN_CYCLES = 10;

    // debounce histories, event ring and pending pops, kept in step with the block
    class key_event_scoreboard;
        localparam string KEY_LAYOUT = "DCBA#9630852*741";
        localparam int    SLOTS      = 2;
        localparam bit [7:0] PRESS_HIST   = 8'h01;
        localparam bit [7:0] RELEASE_HIST = 8'hfe;

        bit [7:0] history [16];
        bit [7:0] ring [SLOTS];
        int       wr_slot;
        int       rd_slot;
        event_t   due_events [$];
        int       mismatches;
        int       n_scans;
        int       n_pops;
        int       n_press;
        int       n_release;
        int       n_empty;

        function new();
            foreach (history[i]) history[i] = '0;
            foreach (ring[i]) ring[i] = '0;
            wr_slot    = 0;
            rd_slot    = 0;
            mismatches = 0;
            n_scans    = 0;
            n_pops     = 0;
            n_press    = 0;
            n_release  = 0;
            n_empty    = 0;
        endfunction

        function void push_code(bit [7:0] code);
            ring[wr_slot] = code;
            wr_slot = (wr_slot + 1) % SLOTS;
        endfunction

        // work out what an accepted beat does to the state and what it returns
        function void note_beat(kind_t kind, bit [1:0] col, bit [3:0] rows);
            int       idx;
            bit [7:0] h;
            bit [7:0] ev;
            byte      code;
            event_t   res;
            if (kind == KIND_SCAN) begin
                n_scans++;
                // rows push in ascending order
                for (int r = 0; r < 4; r++) begin
                    idx = col * 4 + r;
                    h = {history[idx][6:0], rows[r]};
                    history[idx] = h;
                    code = KEY_LAYOUT[idx];
                    if (h == PRESS_HIST)
                        push_code({1'b1, code[6:0]});
                    if (h == RELEASE_HIST)
                        push_code({1'b0, code[6:0]});
                end
            end
            else begin
                n_pops++;
                ev = ring[rd_slot];
                res = '0;
                if (ev != 8'h00) begin
                    ring[rd_slot] = '0;
                    rd_slot = (rd_slot + 1) % SLOTS;
                    res.event_valid = 1'b1;
                    res.pressed     = ev[7];
                    res.key_char    = ev[6:0];
                    if (ev[7]) n_press++;
                    else n_release++;
                end
                else begin
                    n_empty++;
                end
                due_events.push_back(res);
            end
        endfunction

        function void check_event(event_t got);
            event_t want;
            if (due_events.size() == 0) begin
                $error("output beat with nothing pending: %h", got);
                mismatches++;
                return;
            end
            want = due_events.pop_front();
            if (got.event_valid !== want.event_valid) begin
                $error("event_valid: expected %0d, got %0d", want.event_valid, got.event_valid);
                mismatches++;
            end
            if (got.pressed !== want.pressed) begin
                $error("pressed: expected %0d, got %0d", want.pressed, got.pressed);
                mismatches++;
            end
            if (got.key_char !== want.key_char) begin
                $error("key_char: expected %h, got %h", want.key_char, got.key_char);
                mismatches++;
            end
        endfunction

        function int pending();
            return due_events.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // column[1:0], row_bits[5:2], zeros
    logic                  s_tuser;   // kind[0]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // event_valid[0], pressed[1], key_char[8:2], zeros

    key_event_scoreboard sb;
    bit                  no_idle;
    int                  cycle_count = 0;
    bit [3:0]            held_rows [4];

    keypad_debounce_event_queue_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 10 ns clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run length guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side back-pressure, off during the no-idle stretch
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready = 1'b0;
        else
            m_tready = no_idle || ($urandom_range(0, 99) >= 7);
    end

    // result beats checked at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_event(event_t'(m_tdata[EVENT_W:0]));
    end

    // one input beat, held until accepted
    task automatic send_beat(kind_t kind, bit [1:0] col, bit [3:0] rows);
        if (!no_idle && $urandom_range(0, 99) < 7)
        begin
            repeat ($urandom_range(1, 3))
            begin
                @(negedge clk);
                s_tvalid = 1'b0;
            end
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = {2'b00, rows, col};
        do @(posedge clk); while (!s_tready);
        sb.note_beat(kind, col, rows);
    endtask

    task automatic scan(bit [1:0] col, bit [3:0] rows);
        send_beat(KIND_SCAN, col, rows);
    endtask

    task automatic pop_event();
        send_beat(KIND_POP, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    initial
    begin
        int       p;
        bit [1:0] col;
        bit [3:0] rows;
        sb          = new();
        no_idle     = 1'b0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        foreach (held_rows[i]) held_rows[i] = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty pop, four presses overflowing the ring, press then release
        pop_event();
        scan(2'd0, 4'hf);
        repeat (3) pop_event();
        repeat (7) scan(2'd3, 4'hf);
        scan(2'd3, 4'h0);
        repeat (3) pop_event();
        scan(2'd1, 4'h5);
        scan(2'd2, 4'ha);
        repeat (3) pop_event();
        // bounce: lone high sample presses, the low after it does not release
        scan(2'd1, 4'h0);
        pop_event();

        // random: held row patterns per column with occasional bounce, mixed with pops
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            no_idle = (i >= 200 && i < 350);
            if (i == 500)
                wait_drained();
            p = $urandom_range(0, 99);
            if (p < 35)
            begin
                pop_event();
            end
            else
            begin
                col = 2'($urandom_range(0, 3));
                if ($urandom_range(0, 99) < 8)
                    held_rows[col] = 4'($urandom_range(0, 15));
                rows = held_rows[col];
                if ($urandom_range(0, 99) < 4)
                    rows[2'($urandom_range(0, 3))] ^= 1'b1;
                scan(col, rows);
            end
        end
        no_idle = 1'b0;
        @(negedge clk);
        s_tvalid = 1'b0;

        // let the last results drain
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d scans and %0d pops: %0d presses, %0d releases, %0d empty",
                 sb.n_scans, sb.n_pops, sb.n_press, sb.n_release, sb.n_empty);
        $display("mismatches: %0d", sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[files.f]
rtl/kdeq_pkg.sv
rtl/kdeq_hist_ram.sv
rtl/kdeq_event_ring.sv
rtl/keypad_debounce_event_queue_core.sv
rtl/kdeq_checker.sv
verif/tb.sv
